>>> rtl/core/cubic_bezier_easing_solver_top_macros.svh
// Assertion macros shared by the solver modules.
`ifndef CUBIC_BEZIER_EASING_SOLVER_TOP_MACROS_SVH
`define CUBIC_BEZIER_EASING_SOLVER_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CBE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/cbe_pkg.sv
`timescale 1ns / 1ps
package cbe_pkg;

   // The port widths fix the number format at Q.16.
   localparam int FRAC_BITS          = 16;
   localparam int NewtonStepsDefault = 8;
   localparam int BisectStepsDefault = 20;

   localparam int CTRL_X_W = 17;
   localparam int CTRL_Y_W = 18;
   localparam int TOL_W    = 16;
   localparam int PROG_W   = 17;
   localparam int YOUT_W   = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CTRL1_X   = 3'd0,
      CSR_CTRL1_Y   = 3'd1,
      CSR_CTRL2_X   = 3'd2,
      CSR_CTRL2_Y   = 3'd3,
      CSR_TOLERANCE = 3'd4
   } csr_idx_type;

   // Work item handed from the front end to the solver core.
   typedef struct packed {
      logic [PROG_W-1:0] x;        // saturated progress
      logic              over;     // progress was above one
      logic              identity; // identity curve: bypass
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEWTON_EVAL,
      ST_NEWTON_DIV,
      ST_BISECT_EVAL,
      ST_Y_EVAL,
      ST_DONE
   } core_state_type;

   typedef enum logic [2:0] {
      HP_IDLE,
      HP_M1,
      HP_M2,
      HP_M3,
      HP_D1,
      HP_D2
   } poly_state_type;

endpackage

>>> rtl/core/cbe_front.sv
`timescale 1ns / 1ps
`include "cubic_bezier_easing_solver_top_macros.svh"
module cbe_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [cbe_pkg::PROG_W-1:0]       req_progress_x,
   input  logic [cbe_pkg::CTRL_X_W-1:0]     ctrl1_x,
   input  logic signed [cbe_pkg::CTRL_Y_W-1:0] ctrl1_y,
   input  logic [cbe_pkg::CTRL_X_W-1:0]     ctrl2_x,
   input  logic signed [cbe_pkg::CTRL_Y_W-1:0] ctrl2_y,
   input  logic                             pop,
   output logic                             busy,
   output logic                             job_valid,
   output cbe_pkg::job_type                 job
);

   localparam logic [cbe_pkg::PROG_W-1:0] One =
      cbe_pkg::PROG_W'(1) << cbe_pkg::FRAC_BITS;

   cbe_pkg::job_type job_in;
   cbe_pkg::job_type job_ff;
   logic             full_ff;
   logic             full_in;
   logic             accept;

   // Single-entry queue: the block takes one request at a time.
   assign busy   = full_ff;
   assign accept = start && !full_ff;

   always_comb begin
      job_in.over = req_progress_x > One;
      job_in.x    = job_in.over ? One : req_progress_x;
      job_in.identity = (ctrl1_x == '0) && (ctrl1_y == '0)
         && (ctrl2_x == One) && (ctrl2_y == cbe_pkg::CTRL_Y_W'(One));
   end

   always_comb begin
      full_in = full_ff;
      if (accept) begin
         full_in = 1'b1;
      end else if (pop) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = full_ff;
   assign job       = job_ff;

   `CBE_ASSERT_NEXT(a_accept_fills, clock, reset, accept, full_ff)
   `CBE_ASSERT_IMP(a_pop_when_full, clock, reset, pop, full_ff)
   `CBE_ASSERT_IMP(a_sat_x, clock, reset, full_ff, job_ff.x <= One)

endmodule

>>> rtl/core/cbe_core.sv
`timescale 1ns / 1ps
`include "cubic_bezier_easing_solver_top_macros.svh"
module cbe_core #(
   parameter int NEWTON_STEPS = cbe_pkg::NewtonStepsDefault,
   parameter int BISECT_STEPS = cbe_pkg::BisectStepsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  cbe_pkg::job_type                    job,
   input  logic [cbe_pkg::CTRL_X_W-1:0]        ctrl1_x,
   input  logic signed [cbe_pkg::CTRL_Y_W-1:0] ctrl1_y,
   input  logic [cbe_pkg::CTRL_X_W-1:0]        ctrl2_x,
   input  logic signed [cbe_pkg::CTRL_Y_W-1:0] ctrl2_y,
   input  logic [cbe_pkg::TOL_W-1:0]           tolerance,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic signed [cbe_pkg::YOUT_W-1:0]   rsp_eased_y,
   output logic [cbe_pkg::PROG_W-1:0]          rsp_param_t,
   output logic                                rsp_converged
);

   localparam int FRAC_BITS = cbe_pkg::FRAC_BITS;
   // Coefficients reach about 9 * 2^17; products need headroom for t <= ONE.
   localparam int CW = FRAC_BITS + 8;           // coefficient / Horner width
   localparam int PW = 2 * CW;                  // product width
   localparam int QW = CW + FRAC_BITS + 2;      // dividend width
   localparam int NCW = $clog2(NEWTON_STEPS + 1);
   localparam int BCW = $clog2(BISECT_STEPS + 1);
   localparam int DCW = $clog2(QW + 1);
   localparam logic signed [CW-1:0] One = CW'(1) <<< FRAC_BITS;
   localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);

   cbe_pkg::core_state_type st_ff, st_in;
   cbe_pkg::poly_state_type ph_ff, ph_in;

   logic signed [CW-1:0] ax, bx, cx, ay, by, cy;
   logic signed [CW-1:0] t_ff, t_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [CW-1:0] x_ff;
   logic signed [CW-1:0] acc_ff, acc_in;   // Horner accumulator
   logic signed [CW-1:0] d_ff, d_in;
   logic [NCW-1:0]       nc_ff, nc_in;
   logic [BCW-1:0]       bc_ff, bc_in;
   logic                 conv_ff, conv_in, over_ff, over_in;
   logic                 out_v_ff, out_v_in;
   logic signed [CW-1:0] y_ff, y_in;

   // Shared multiplier with Q rounding (ties toward +inf).
   logic signed [CW-1:0] ma, mb, mq;
   logic signed [PW-1:0] mp;
   assign mp = ma * mb + Half;
   assign mq = CW'(mp >>> FRAC_BITS);

   // Restoring divider over magnitudes, one quotient bit per cycle.
   logic [QW-1:0] dq_ff, dq_in, dr_ff, dr_in, dv_ff, dv_in;
   logic [QW:0]   dtrial;
   logic [DCW-1:0] dc_ff, dc_in;
   logic          dneg_ff, dneg_in;
   logic signed [QW+1:0] tnew;

   always_comb begin
      cx = CW'(3 * CW'(signed'({1'b0, ctrl1_x})));
      bx = CW'(3 * (CW'(signed'({1'b0, ctrl2_x})) - CW'(signed'({1'b0, ctrl1_x}))) - cx);
      ax = One - cx - bx;
      cy = CW'(3 * CW'(ctrl1_y));
      by = CW'(3 * (CW'(ctrl2_y) - CW'(ctrl1_y)) - cy);
      ay = One - cy - by;
   end

   logic signed [CW-1:0] abs_err;
   logic signed [CW-1:0] tol_s;
   assign tol_s = CW'(signed'({1'b0, tolerance}));
   assign abs_err = (acc_ff - x_ff) < 0 ? x_ff - acc_ff : acc_ff - x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= cbe_pkg::ST_IDLE;
         ph_ff    <= cbe_pkg::HP_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         ph_ff    <= ph_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; lo_ff <= lo_in; hi_ff <= hi_in; acc_ff <= acc_in;
      d_ff <= d_in; nc_ff <= nc_in; bc_ff <= bc_in;
      conv_ff <= conv_in; over_ff <= over_in; y_ff <= y_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dv_ff <= dv_in; dc_ff <= dc_in;
      dneg_ff <= dneg_in;
      if (st_ff == cbe_pkg::ST_IDLE && job_valid) begin
         x_ff <= CW'(signed'({1'b0, job.x}));
      end
   end

   assign dtrial = {dr_ff, dq_ff[QW-1]} - {1'b0, dv_ff};
   assign tnew = (QW+2)'(t_ff) - (dneg_ff ? -(QW+2)'(signed'({2'b0, dq_ff}))
                                          :  (QW+2)'(signed'({2'b0, dq_ff})));

   // Horner step: M1..M3 compute ((a*t+b)*t+c)*t; Newton adds derivative in D1..D2.
   always_comb begin
      logic signed [QW-1:0] num;
      st_in = st_ff; ph_in = ph_ff;
      t_in = t_ff; lo_in = lo_ff; hi_in = hi_ff; acc_in = acc_ff;
      d_in = d_ff; nc_in = nc_ff; bc_in = bc_ff;
      conv_in = conv_ff; over_in = over_ff; y_in = y_ff; out_v_in = 1'b0;
      dq_in = dq_ff; dr_in = dr_ff; dv_in = dv_ff; dc_in = dc_ff; dneg_in = dneg_ff;
      pop = 1'b0;
      ma = t_ff; mb = ax;
      num = '0;
      unique case (st_ff)
         cbe_pkg::ST_IDLE: begin
            if (job_valid) begin
               t_in = CW'(signed'({1'b0, job.x}));
               over_in = job.over; conv_in = 1'b0;
               nc_in = '0; bc_in = '0;
               lo_in = '0; hi_in = One;
               if (job.identity) begin
                  y_in = CW'(signed'({1'b0, job.x}));
                  conv_in = 1'b1;
                  st_in = cbe_pkg::ST_DONE;
               end else begin
                  ph_in = cbe_pkg::HP_M1;
                  st_in = (NEWTON_STEPS > 0) ? cbe_pkg::ST_NEWTON_EVAL
                                             : cbe_pkg::ST_BISECT_EVAL;
               end
            end
         end
         cbe_pkg::ST_NEWTON_EVAL, cbe_pkg::ST_BISECT_EVAL, cbe_pkg::ST_Y_EVAL: begin
            unique case (ph_ff)
               cbe_pkg::HP_M1: begin
                  ma = (st_ff == cbe_pkg::ST_Y_EVAL) ? ay : ax;
                  mb = t_ff;
                  acc_in = mq + ((st_ff == cbe_pkg::ST_Y_EVAL) ? by : bx);
                  ph_in = cbe_pkg::HP_M2;
               end
               cbe_pkg::HP_M2: begin
                  ma = acc_ff; mb = t_ff;
                  acc_in = mq + ((st_ff == cbe_pkg::ST_Y_EVAL) ? cy : cx);
                  ph_in = cbe_pkg::HP_M3;
               end
               cbe_pkg::HP_M3: begin
                  ma = acc_ff; mb = t_ff;
                  acc_in = mq;
                  ph_in = (st_ff == cbe_pkg::ST_NEWTON_EVAL) ? cbe_pkg::HP_D1
                                                            : cbe_pkg::HP_IDLE;
               end
               cbe_pkg::HP_D1: begin
                  ma = CW'(3 * ax); mb = t_ff;
                  d_in = CW'(mq + 2 * bx);
                  ph_in = cbe_pkg::HP_D2;
               end
               cbe_pkg::HP_D2: begin
                  ma = d_ff; mb = t_ff;
                  d_in = mq + cx;
                  ph_in = cbe_pkg::HP_IDLE;
               end
               default: begin
                  // Evaluation finished: decide.
                  priority if (st_ff == cbe_pkg::ST_Y_EVAL) begin
                     y_in = acc_ff;
                     st_in = cbe_pkg::ST_DONE;
                  end else if (abs_err < tol_s) begin
                     conv_in = 1'b1;
                     ph_in = cbe_pkg::HP_M1;
                     st_in = cbe_pkg::ST_Y_EVAL;
                  end else if (st_ff == cbe_pkg::ST_NEWTON_EVAL) begin
                     if (d_ff == '0) begin
                        t_in = x_ff; ph_in = cbe_pkg::HP_M1;
                        st_in = cbe_pkg::ST_BISECT_EVAL;
                     end else begin
                        num = QW'(acc_ff - x_ff) <<< FRAC_BITS;
                        dneg_in = num[QW-1] ^ d_ff[CW-1];
                        dq_in = num[QW-1] ? QW'(-num) : QW'(num);
                        dv_in = d_ff[CW-1] ? QW'(-d_ff) : QW'(d_ff);
                        dr_in = '0; dc_in = DCW'(QW);
                        st_in = cbe_pkg::ST_NEWTON_DIV;
                     end
                  end else begin
                     if (x_ff > acc_ff) lo_in = t_ff;
                     else hi_in = t_ff;
                     t_in = (x_ff > acc_ff) ? t_ff + ((hi_ff - t_ff) >>> 1)
                                            : lo_ff + ((t_ff - lo_ff) >>> 1);
                     bc_in = bc_ff + 1'b1;
                     ph_in = cbe_pkg::HP_M1;
                     if (bc_ff == BCW'(BISECT_STEPS - 1)) begin
                        t_in = t_ff;
                        st_in = cbe_pkg::ST_Y_EVAL;
                     end
                  end
               end
            endcase
            // After last bisection move, the new t is not tested (model exits loop).
            if (st_ff == cbe_pkg::ST_BISECT_EVAL && ph_ff == cbe_pkg::HP_IDLE
                && !(abs_err < tol_s) && bc_ff == BCW'(BISECT_STEPS - 1)) begin
               t_in = (x_ff > acc_ff) ? t_ff + ((hi_ff - t_ff) >>> 1)
                                      : lo_ff + ((t_ff - lo_ff) >>> 1);
            end
         end
         cbe_pkg::ST_NEWTON_DIV: begin
            if (dc_ff != '0) begin
               dc_in = dc_ff - 1'b1;
               if (!dtrial[QW]) begin
                  dr_in = dtrial[QW-1:0];
                  dq_in = {dq_ff[QW-2:0], 1'b1};
               end else begin
                  dr_in = {dr_ff[QW-2:0], dq_ff[QW-1]};
                  dq_in = {dq_ff[QW-2:0], 1'b0};
               end
            end else begin
               priority if (tnew < 0) t_in = '0;
               else if (tnew > (QW+2)'(One)) t_in = One;
               else t_in = CW'(tnew);
               nc_in = nc_ff + 1'b1;
               ph_in = cbe_pkg::HP_M1;
               if (nc_ff == NCW'(NEWTON_STEPS - 1)) begin
                  t_in = (tnew < 0) ? '0 : (tnew > (QW+2)'(One)) ? One : CW'(tnew);
                  st_in = cbe_pkg::ST_BISECT_EVAL;
                  // bisection restarts from x
                  t_in = x_ff;
               end else begin
                  st_in = cbe_pkg::ST_NEWTON_EVAL;
               end
            end
         end
         cbe_pkg::ST_DONE: begin
            out_v_in = 1'b1;
            pop = 1'b1;
            st_in = cbe_pkg::ST_IDLE;
         end
         default: st_in = cbe_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = out_v_ff;
   always_ff @(posedge clock) begin
      if (st_ff == cbe_pkg::ST_DONE) begin
         rsp_eased_y <= (y_ff > CW'(131071)) ? 18'sd131071 :
                        (y_ff < -CW'(131072)) ? -18'sd131072 : cbe_pkg::YOUT_W'(y_ff);
         rsp_param_t <= cbe_pkg::PROG_W'(t_ff);
         rsp_converged <= conv_ff && !over_ff;
      end
   end

   `CBE_ASSERT_NEXT(a_done_strobe, clock, reset, st_ff == cbe_pkg::ST_DONE, rsp_valid)
   `CBE_ASSERT_IMP(a_t_range, clock, reset, st_ff == cbe_pkg::ST_BISECT_EVAL,
      t_ff >= 0 && t_ff <= One)
   `CBE_ASSERT_IMP(a_pop_done, clock, reset, pop, st_ff == cbe_pkg::ST_DONE)

endmodule

>>> rtl/core/cubic_bezier_easing_solver_top.sv
`timescale 1ns / 1ps
// Channel   | Ports                                      | Handshake
// request   | start, busy, req_progress_x                | start && !busy
// response  | rsp_valid, rsp_eased_y/param_t/converged   | one-cycle strobe
// config    | csr_write, csr_index, csr_data             | write enable only
//
// On the identity curve the core bypasses the search and goes straight to the
// response. Otherwise each Newton step runs five multiplies on the shared
// multiplier, a decision and a bit-serial divide; each bisection step and the
// final y evaluation run three multiplies and a decision.
// Reset is synchronous and active high; it empties the request slot and
// restores the control points to the identity curve with tolerance sixteen.
// The receiver cannot stall; busy stays high until the response strobe.
module cubic_bezier_easing_solver_top #(
   parameter int NEWTON_STEPS = cbe_pkg::NewtonStepsDefault,
   parameter int BISECT_STEPS = cbe_pkg::BisectStepsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cbe_pkg::PROG_W-1:0]           req_progress_x,
   output logic                                 rsp_valid,
   output logic signed [cbe_pkg::YOUT_W-1:0]    rsp_eased_y,
   output logic [cbe_pkg::PROG_W-1:0]           rsp_param_t,
   output logic                                 rsp_converged,
   input  logic                                 csr_write,
   input  logic [cbe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cbe_pkg::CSR_DATA_W-1:0]       csr_data
);

   logic [cbe_pkg::CTRL_X_W-1:0]        c1x_ff, c2x_ff;
   logic signed [cbe_pkg::CTRL_Y_W-1:0] c1y_ff, c2y_ff;
   logic [cbe_pkg::TOL_W-1:0]           tol_ff;
   logic             job_valid, pop;
   cbe_pkg::job_type job;

   // Configuration registers; reset gives the identity curve.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= '0;
         c1y_ff <= '0;
         c2x_ff <= cbe_pkg::CTRL_X_W'(1) << cbe_pkg::FRAC_BITS;
         c2y_ff <= cbe_pkg::CTRL_Y_W'(1) << cbe_pkg::FRAC_BITS;
         tol_ff <= cbe_pkg::TOL_W'(16);
      end else if (csr_write) begin
         unique case (csr_index)
            cbe_pkg::CSR_CTRL1_X:   c1x_ff <= csr_data[cbe_pkg::CTRL_X_W-1:0];
            cbe_pkg::CSR_CTRL1_Y:   c1y_ff <= csr_data;
            cbe_pkg::CSR_CTRL2_X:   c2x_ff <= csr_data[cbe_pkg::CTRL_X_W-1:0];
            cbe_pkg::CSR_CTRL2_Y:   c2y_ff <= csr_data;
            cbe_pkg::CSR_TOLERANCE: tol_ff <= csr_data[cbe_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Front end: saturates progress and spots the identity curve.
   cbe_front u_front (
      .clock, .reset, .start, .req_progress_x,
      .ctrl1_x(c1x_ff), .ctrl1_y(c1y_ff), .ctrl2_x(c2x_ff), .ctrl2_y(c2y_ff),
      .pop, .busy, .job_valid, .job
   );

   // Back end: Newton then bisection on a shared multiplier and divider.
   cbe_core #(.NEWTON_STEPS(NEWTON_STEPS), .BISECT_STEPS(BISECT_STEPS)) u_core (
      .clock, .reset, .job_valid, .job,
      .ctrl1_x(c1x_ff), .ctrl1_y(c1y_ff), .ctrl2_x(c2x_ff), .ctrl2_y(c2y_ff),
      .tolerance(tol_ff), .pop, .rsp_valid, .rsp_eased_y, .rsp_param_t,
      .rsp_converged
   );

endmodule

>>> test/cubic_bezier_easing_solver_top_test.sv
`timescale 1ns / 1ps
module cubic_bezier_easing_solver_top_test;

   localparam longint UNIT = 64'sd65536;
   // Watchdog limit on cycles in which no request or response is taken.
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [cbe_pkg::PROG_W-1:0] req_progress_x = '0;
   logic rsp_valid;
   logic signed [cbe_pkg::YOUT_W-1:0] rsp_eased_y;
   logic [cbe_pkg::PROG_W-1:0] rsp_param_t;
   logic rsp_converged;
   logic csr_write = 1'b0;
   logic [cbe_pkg::CSR_IDX_W-1:0] csr_index = cbe_pkg::CSR_CTRL1_X;
   logic [cbe_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // One expected response of the solver.
   typedef struct packed {
      logic signed [cbe_pkg::YOUT_W-1:0] y;
      logic [cbe_pkg::PROG_W-1:0] t;
      logic conv;
   } easing_type;

   easing_type expected_easing[$];

   // The testbench's own copy of the control registers.
   logic [cbe_pkg::CTRL_X_W-1:0] p1x_reg, p2x_reg;
   logic [cbe_pkg::CTRL_Y_W-1:0] p1y_reg, p2y_reg;
   logic [cbe_pkg::TOL_W-1:0] tol_reg;

   int mismatches = 0;
   int checked = 0;
   int idle_percent = 0;
   int quiet_cycles = 0;
   int settings_run = 0;

   always #1 clock = ~clock;

   cubic_bezier_easing_solver_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_progress_x(req_progress_x), .rsp_valid(rsp_valid),
      .rsp_eased_y(rsp_eased_y), .rsp_param_t(rsp_param_t),
      .rsp_converged(rsp_converged), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Fixed-point product, rounded to nearest with ties toward +infinity.
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b + UNIT / 2;
      return p >>> 16;
   endfunction

   function automatic longint horner(longint a, longint b, longint c, longint t);
      longint h;
      h = qmul(a, t) + b;
      h = qmul(h, t) + c;
      return qmul(h, t);
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Works out the solved point for one progress value under the current registers.
   function automatic easing_type solve_easing(logic [cbe_pkg::PROG_W-1:0] progress);
      longint p1x, p2x, p1y, p2y, tol, x, t, y, cx, bx, ax, cy, by, ay;
      longint err, d, lo, hi, xs;
      bit over, conv;
      easing_type r;
      p1x = p1x_reg;
      p2x = p2x_reg;
      p1y = longint'($signed(p1y_reg));
      p2y = longint'($signed(p2y_reg));
      tol = tol_reg;
      x = progress;
      over = 0;
      conv = 0;
      if (x > UNIT) begin
         x = UNIT;
         over = 1;
      end
      if (p1x == 0 && p1y == 0 && p2x == UNIT && p2y == UNIT) begin
         t = x;
         y = x;
         conv = 1;
      end else begin
         cx = 3 * p1x;
         bx = 3 * (p2x - p1x) - cx;
         ax = UNIT - cx - bx;
         cy = 3 * p1y;
         by = 3 * (p2y - p1y) - cy;
         ay = UNIT - cy - by;
         t = x;
         for (int i = 0; i < cbe_pkg::NewtonStepsDefault; i++) begin
            err = horner(ax, bx, cx, t) - x;
            if (magnitude(err) < tol) begin
               conv = 1;
               break;
            end
            d = qmul(qmul(3 * ax, t) + 2 * bx, t) + cx;
            if (d == 0) break;
            t -= (err * UNIT) / d;
            if (t < 0) t = 0;
            if (t > UNIT) t = UNIT;
         end
         if (!conv) begin
            lo = 0;
            hi = UNIT;
            t = x;
            for (int i = 0; i < cbe_pkg::BisectStepsDefault; i++) begin
               xs = horner(ax, bx, cx, t);
               if (magnitude(xs - x) < tol) begin
                  conv = 1;
                  break;
               end
               if (x > xs) lo = t;
               else hi = t;
               t = lo + ((hi - lo) >>> 1);
            end
         end
         y = horner(ay, by, cy, t);
      end
      if (over) conv = 0;
      if (y > 131071) y = 131071;
      if (y < -131072) y = -131072;
      r.y = y[cbe_pkg::YOUT_W-1:0];
      r.t = t[cbe_pkg::PROG_W-1:0];
      r.conv = conv;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Checks each response strobe against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_easing.size() == 0) begin
            report_mismatch("unexpected response count", 1, 0);
         end else begin
            easing_type e;
            e = expected_easing.pop_front();
            checked++;
            if (rsp_eased_y !== e.y) report_mismatch("eased_y", rsp_eased_y, e.y);
            if (rsp_param_t !== e.t) report_mismatch("param_t", rsp_param_t, e.t);
            if (rsp_converged !== e.conv)
               report_mismatch("converged", rsp_converged, e.conv);
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a response is taken.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding",
                     expected_easing.size());
            $display("cubic_bezier_easing_solver_top_test: errors");
            $finish;
         end
      end
   end

   // Sends one request, with a random idle gap first in the idling phases.
   // Start stays high after acceptance; the block is busy then, and the next
   // request, an idle gap or a drain takes it over.
   task automatic send_progress(logic [cbe_pkg::PROG_W-1:0] progress);
      while (idle_percent > 0 && $urandom_range(99, 0) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_progress_x <= progress;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_easing.push_back(solve_easing(progress));
   endtask

   // Waits for every response, then lets the solver settle.
   task automatic drain_responses();
      start <= 1'b0;
      while (expected_easing.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(cbe_pkg::csr_idx_type idx,
                                 logic [cbe_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         cbe_pkg::CSR_CTRL1_X:   p1x_reg = value[cbe_pkg::CTRL_X_W-1:0];
         cbe_pkg::CSR_CTRL1_Y:   p1y_reg = value[cbe_pkg::CTRL_Y_W-1:0];
         cbe_pkg::CSR_CTRL2_X:   p2x_reg = value[cbe_pkg::CTRL_X_W-1:0];
         cbe_pkg::CSR_CTRL2_Y:   p2y_reg = value[cbe_pkg::CTRL_Y_W-1:0];
         cbe_pkg::CSR_TOLERANCE: tol_reg = value[cbe_pkg::TOL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_curve(int x1, int y1, int x2, int y2, int tol);
      drain_responses();
      write_register(cbe_pkg::CSR_CTRL1_X, cbe_pkg::CSR_DATA_W'(x1));
      write_register(cbe_pkg::CSR_CTRL1_Y, cbe_pkg::CSR_DATA_W'(y1));
      write_register(cbe_pkg::CSR_CTRL2_X, cbe_pkg::CSR_DATA_W'(x2));
      write_register(cbe_pkg::CSR_CTRL2_Y, cbe_pkg::CSR_DATA_W'(y2));
      write_register(cbe_pkg::CSR_TOLERANCE, cbe_pkg::CSR_DATA_W'(tol));
      csr_write <= 1'b0;
      settings_run++;
   endtask

   // The reset curve is the identity, so responses are bypassed.
   task automatic test_identity_bypass();
      send_progress(17'd0);
      send_progress(17'h10000);
      send_progress(17'h1FFFF);
      send_progress(17'd12345);
   endtask

   // Ease-type curve with the field extremes and progress above one.
   task automatic test_directed_curves();
      set_curve(16384, 6554, 16384, 65536, 16);
      send_progress(17'd0);
      send_progress(17'd1);
      send_progress(17'd32768);
      send_progress(17'd65535);
      send_progress(17'd65536);
      send_progress(17'd65537);
      send_progress(17'h1FFFF);
      send_progress(17'h0AAAA);
      send_progress(17'h15555);
      // Zero tolerance: no step can converge, the search always fails.
      set_curve(27525, 0, 38011, 65536, 0);
      send_progress(17'd1000);
      send_progress(17'd50000);
      // Control x at one and extreme y values.
      set_curve(65536, -131072, 65536, 131071, 65535);
      send_progress(17'd20000);
      send_progress(17'd65536);
      // Flat derivative at the midpoint makes Newton give way to bisection.
      set_curve(65536, 131071, 0, -131072, 1);
      send_progress(17'd100);
      send_progress(17'd40000);
      set_curve(0, 0, 0, 0, 16);
      send_progress(17'd30000);
      send_progress(17'd65535);
   endtask

   task automatic send_random_batch(int count);
      logic [cbe_pkg::PROG_W-1:0] p;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3, 0))
            0: p = cbe_pkg::PROG_W'($urandom_range(131071, 0));
            1: p = cbe_pkg::PROG_W'($urandom_range(65536, 65530));
            default: p = cbe_pkg::PROG_W'($urandom_range(65536, 0));
         endcase
         send_progress(p);
      end
   endtask

   // Random curves across the idling phases; the tolerance is mostly small.
   task automatic test_random_curves();
      int phases[4] = '{0, 54, 0, 10};
      for (int k = 0; k < 16; k++) begin
         idle_percent = phases[k % 4];
         set_curve($urandom_range(65536, 0), $urandom_range(262143, 0),
                   $urandom_range(65536, 0), $urandom_range(262143, 0),
                   ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
                                               : $urandom_range(64, 1));
         send_random_batch(50);
         // Once, hold off until every response has arrived.
         if (k == 5) drain_responses();
         send_random_batch(6);
      end
      idle_percent = 0;
   endtask

   initial begin
      p1x_reg = '0;
      p1y_reg = '0;
      p2x_reg = 17'h10000;
      p2y_reg = 18'h10000;
      tol_reg = 16'd16;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_bypass();
      test_directed_curves();
      test_random_curves();
      drain_responses();
      repeat (50) @(posedge clock);
      $display("Checked %0d responses over %0d register settings, with and without idling.",
               checked, settings_run);
      if (mismatches == 0 && expected_easing.size() == 0) begin
         $display("cubic_bezier_easing_solver_top_test: clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  expected_easing.size());
         $display("cubic_bezier_easing_solver_top_test: errors");
      end
      $finish;
   end

endmodule
